/* hw/rtl/point_in_polygon_test_core_assert.svh */
// ----------------------------------------------------------------------------
// point in polygon assertion macros
// concurrent checks that vanish in synthesis builds
// ----------------------------------------------------------------------------
`ifndef POINT_IN_POLYGON_TEST_CORE_ASSERT_SVH
`define POINT_IN_POLYGON_TEST_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication under active-low reset
`define PIP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("pip assertion failed");
// next-cycle implication under active-low reset
`define PIP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("pip assertion failed");
`else
`define PIP_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define PIP_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

/* hw/rtl/pip_pkg.sv */
// ----------------------------------------------------------------------------
// pip_pkg
// shared types and constants of the point in polygon test core
// ----------------------------------------------------------------------------
`default_nettype none

package pip_pkg;

  // fixed field widths
  localparam int unsigned IDX_W       = 6;
  localparam int unsigned VCNT_W      = 7;
  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 8;

  // opcodes of an input word
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_VERTEX_COUNT = 1'b0;

  // query sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIRST,
    ST_LOAD,
    ST_MUL1,
    ST_MUL2,
    ST_CMP,
    ST_DONE
  } st_e;

  // multiplier unit control
  typedef struct packed {
    logic load_first;
    logic load_second;
  } mul_ctrl_t;

  // sign of first product minus second product
  typedef struct packed {
    logic zero;
    logic neg;
  } cmp_t;

endpackage

`default_nettype wire

/* hw/rtl/pip_mul_unit.sv */
// ----------------------------------------------------------------------------
// pip_mul_unit
// shared signed multiplier holding two products and their exact sign compare
// ----------------------------------------------------------------------------
`default_nettype none

module pip_mul_unit #(
  parameter int unsigned DW = 17
) (
  input  wire logic                  clk_i,
  input  wire pip_pkg::mul_ctrl_t    ctrl_i,
  input  wire logic signed [DW-1:0]  op_a_i,
  input  wire logic signed [DW-1:0]  op_b_i,
  output      pip_pkg::cmp_t         cmp_o
);

  localparam int unsigned PW = 2 * DW;

  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] p1_q;
  logic signed [PW-1:0] p2_q;
  logic signed [PW:0]   diff;

  // one multiplier, result registered only on a load strobe
  assign prod = PW'(op_a_i) * PW'(op_b_i);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_first) begin
      p1_q <= prod;
    end
    if (ctrl_i.load_second) begin
      p2_q <= prod;
    end
  end

  // exact difference of the held products
  assign diff       = {p1_q[PW-1], p1_q} - {p2_q[PW-1], p2_q};
  assign cmp_o.zero = (diff == '0);
  assign cmp_o.neg  = diff[PW];

endmodule

`default_nettype wire

/* hw/rtl/point_in_polygon_test_core.sv */
// ----------------------------------------------------------------------------
// point_in_polygon_test_core
// vertex write: acknowledge word out through the done state; query: edge walk
// for n >= 3 vertices in use, answered outside at once when fewer are in use
// the edge walk runs each edge through load, mul1, mul2 and cmp on the single shared multiplier
// next word accepted once back in idle; reset clears count, sequencer and output valid only
// ----------------------------------------------------------------------------
`default_nettype none

`include "point_in_polygon_test_core_assert.svh"

module point_in_polygon_test_core #(
  parameter int unsigned MAX_VERTICES = 64,
  parameter int unsigned COORD_BITS   = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  // input words
  input  wire logic s_axis_tvalid,
  output      logic s_axis_tready,
  // tdata: vertex_index, coord_x, coord_y, zero fill
  input  wire logic [((pip_pkg::IDX_W + 2 * COORD_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // tuser: opcode
  input  wire logic s_axis_tuser,
  // result words
  output      logic m_axis_tvalid,
  input  wire logic m_axis_tready,
  // tdata: inside_res, zero fill
  output      logic [pip_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // tuser: is_answer
  output      logic m_axis_tuser,
  // configuration
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [pip_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [pip_pkg::APB_DATA_W-1:0] pwdata,
  output      logic [pip_pkg::APB_DATA_W-1:0] prdata,
  output      logic pready
);

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned DW = CB + 1;
  localparam int unsigned AW = $clog2(MAX_VERTICES);
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned NW = (CW > pip_pkg::VCNT_W) ? CW : pip_pkg::VCNT_W;
  localparam int unsigned IW = pip_pkg::IDX_W;

  // configuration register
  logic [pip_pkg::VCNT_W-1:0] vcount_q;
  logic                       cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready &&
                  (paddr[2] == pip_pkg::REG_VERTEX_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= '0;
    end else if (cfg_we) begin
      vcount_q <= pwdata[pip_pkg::VCNT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == pip_pkg::REG_VERTEX_COUNT) ?
                  {(pip_pkg::APB_DATA_W - pip_pkg::VCNT_W)'(0), vcount_q} : '0;

  // input word fields
  logic                 in_op;
  logic [IW-1:0]        in_idx;
  logic signed [CB-1:0] in_x;
  logic signed [CB-1:0] in_y;
  logic                 in_acc;

  assign in_op  = s_axis_tuser;
  assign in_idx = s_axis_tdata[IW-1:0];
  assign in_x   = s_axis_tdata[IW +: CB];
  assign in_y   = s_axis_tdata[IW + CB +: CB];
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // write address and range check
  logic [AW+IW-1:0] idx_ext;
  logic             idx_ok;

  assign idx_ext = {AW'(0), in_idx};
  assign idx_ok  = idx_ext < (AW + IW)'(MAX_VERTICES);

  // vertex count clamped to the table depth
  logic [NW-1:0] vc_ext;
  logic [NW-1:0] max_ext;
  logic [CW-1:0] n_clamped;
  logic          too_few;

  assign vc_ext    = NW'(vcount_q);
  assign max_ext   = NW'(MAX_VERTICES);
  assign n_clamped = (vc_ext > max_ext) ? max_ext[CW-1:0] : vc_ext[CW-1:0];
  assign too_few   = n_clamped < CW'(3);

  // sequencer and datapath registers
  pip_pkg::st_e state_q, state_d;

  logic [CW-1:0]        n_q, n_d;
  logic [CW-1:0]        k_q, k_d;
  logic [AW-1:0]        addr_q, addr_d;
  logic                 parity_q, parity_d;
  logic                 cross_q, cross_d;
  logic                 dyneg_q, dyneg_d;
  logic                 res_answer_q, res_answer_d;
  logic                 res_inside_q, res_inside_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_answer_q, out_answer_d;
  logic                 out_inside_q, out_inside_d;
  logic signed [CB-1:0] px_q, px_d, py_q, py_d;
  logic signed [CB-1:0] fx_q, fx_d, fy_q, fy_d;
  logic signed [CB-1:0] ax_q, ax_d, ay_q, ay_d;
  logic signed [CB-1:0] bx_q, bx_d, by_q, by_d;

  // vertex memory, registered read
  logic [2*CB-1:0]      mem_q [MAX_VERTICES];
  logic [2*CB-1:0]      rdata_q;
  logic                 mem_we;
  logic signed [CB-1:0] rd_x;
  logic signed [CB-1:0] rd_y;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[idx_ext[AW-1:0]] <= {in_y, in_x};
    end
    rdata_q <= mem_q[addr_d];
  end

  assign rd_x = rdata_q[CB-1:0];
  assign rd_y = rdata_q[2*CB-1:CB];

  // edge classification against the point's horizontal line
  logic edge_cross;
  logic edge_on_level;
  logic last_edge;
  logic wrap;
  logic [CW-1:0] k_next;
  logic out_free;

  assign edge_cross    = ((ay_q >= py_q) && (by_q < py_q)) ||
                         ((ay_q < py_q) && (by_q >= py_q));
  assign edge_on_level = (ay_q == py_q) && (by_q == py_q) &&
                         (((ax_q >= px_q) && (bx_q <= px_q)) ||
                          ((ax_q <= px_q) && (bx_q >= px_q)));
  assign wrap          = (k_q == n_q);
  assign last_edge     = wrap;
  assign k_next        = k_q + CW'(1);
  assign out_free      = !out_valid_q || m_axis_tready;

  // shared multiplier: (ax-bx)*(py-by) first, then (px-bx)*(ay-by)
  pip_pkg::mul_ctrl_t   mul_ctrl;
  pip_pkg::cmp_t        cmp;
  logic signed [DW-1:0] op_a;
  logic signed [DW-1:0] op_b;
  logic                 second_op;
  logic                 cmp_hit;
  logic                 cmp_count;

  assign second_op = (state_q == pip_pkg::ST_MUL2);
  assign op_a = DW'(second_op ? px_q : ax_q) - DW'(bx_q);
  assign op_b = DW'(second_op ? ay_q : py_q) - DW'(by_q);

  pip_mul_unit #(
    .DW (DW)
  ) u_mul (
    .clk_i  (clk_i),
    .ctrl_i (mul_ctrl),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .cmp_o  (cmp)
  );

  // crossing exactly at the point, or strictly to its right
  assign cmp_hit   = cross_q && cmp.zero;
  assign cmp_count = cross_q && !cmp.zero && (cmp.neg == dyneg_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pip_pkg::ST_IDLE: begin
        if (in_acc) begin
          if ((in_op == pip_pkg::OP_QUERY) && !too_few) begin
            state_d = pip_pkg::ST_FIRST;
          end else begin
            state_d = pip_pkg::ST_DONE;
          end
        end
      end
      pip_pkg::ST_FIRST: state_d = pip_pkg::ST_LOAD;
      pip_pkg::ST_LOAD:  state_d = pip_pkg::ST_MUL1;
      pip_pkg::ST_MUL1: begin
        state_d = edge_on_level ? pip_pkg::ST_DONE : pip_pkg::ST_MUL2;
      end
      pip_pkg::ST_MUL2:  state_d = pip_pkg::ST_CMP;
      pip_pkg::ST_CMP: begin
        state_d = (cmp_hit || last_edge) ? pip_pkg::ST_DONE : pip_pkg::ST_LOAD;
      end
      pip_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = pip_pkg::ST_IDLE;
        end
      end
      default: state_d = pip_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    n_d          = n_q;
    k_d          = k_q;
    addr_d       = addr_q;
    parity_d     = parity_q;
    cross_d      = cross_q;
    dyneg_d      = dyneg_q;
    res_answer_d = res_answer_q;
    res_inside_d = res_inside_q;
    out_valid_d  = out_valid_q;
    out_answer_d = out_answer_q;
    out_inside_d = out_inside_q;
    px_d         = px_q;
    py_d         = py_q;
    fx_d         = fx_q;
    fy_d         = fy_q;
    ax_d         = ax_q;
    ay_d         = ay_q;
    bx_d         = bx_q;
    by_d         = by_q;
    mem_we       = 1'b0;
    mul_ctrl     = '0;
    s_axis_tready = (state_q == pip_pkg::ST_IDLE);

    // result word taken
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      pip_pkg::ST_IDLE: begin
        if (in_acc) begin
          px_d         = in_x;
          py_d         = in_y;
          n_d          = n_clamped;
          k_d          = '0;
          addr_d       = '0;
          parity_d     = 1'b0;
          res_answer_d = in_op;
          res_inside_d = 1'b0;
          mem_we       = (in_op == pip_pkg::OP_WRITE) && idx_ok;
        end
      end
      pip_pkg::ST_FIRST: begin
        fx_d   = rd_x;
        fy_d   = rd_y;
        ax_d   = rd_x;
        ay_d   = rd_y;
        k_d    = CW'(1);
        addr_d = AW'(1);
      end
      pip_pkg::ST_LOAD: begin
        bx_d = wrap ? fx_q : rd_x;
        by_d = wrap ? fy_q : rd_y;
      end
      pip_pkg::ST_MUL1: begin
        mul_ctrl.load_first = 1'b1;
        cross_d = edge_cross;
        dyneg_d = ay_q < by_q;
        addr_d  = (k_next < n_q) ? k_next[AW-1:0] : '0;
        if (edge_on_level) begin
          res_inside_d = 1'b1;
        end
      end
      pip_pkg::ST_MUL2: begin
        mul_ctrl.load_second = 1'b1;
      end
      pip_pkg::ST_CMP: begin
        parity_d = parity_q ^ cmp_count;
        if (cmp_hit) begin
          res_inside_d = 1'b1;
        end else if (last_edge) begin
          res_inside_d = parity_q ^ cmp_count;
        end else begin
          ax_d = bx_q;
          ay_d = by_q;
          k_d  = k_next;
        end
      end
      pip_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_answer_d = res_answer_q;
          out_inside_d = res_inside_q;
        end
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pip_pkg::ST_IDLE;
      n_q         <= '0;
      k_q         <= '0;
      addr_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      k_q         <= k_d;
      addr_q      <= addr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    parity_q     <= parity_d;
    cross_q      <= cross_d;
    dyneg_q      <= dyneg_d;
    res_answer_q <= res_answer_d;
    res_inside_q <= res_inside_d;
    out_answer_q <= out_answer_d;
    out_inside_q <= out_inside_d;
    px_q         <= px_d;
    py_q         <= py_d;
    fx_q         <= fx_d;
    fy_q         <= fy_d;
    ax_q         <= ax_d;
    ay_q         <= ay_d;
    bx_q         <= bx_d;
    by_q         <= by_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_answer_q;
  assign m_axis_tdata  = {(pip_pkg::OUT_TDATA_W - 1)'(0), out_inside_q};

  // edge walk never runs past the closing edge
  `PIP_ASSERT_IMP(a_k_bound, clk_i, rst_ni,
    (state_q != pip_pkg::ST_IDLE) && (state_q != pip_pkg::ST_DONE), k_q <= n_q)

  // a query with fewer than three vertices answers outside at once
  `PIP_ASSERT_NXT(a_short_query, clk_i, rst_ni,
    in_acc && (in_op == pip_pkg::OP_QUERY) && too_few,
    (state_q == pip_pkg::ST_DONE) && res_answer_q && !res_inside_q)

  // a vertex write is acknowledged without an answer flag
  `PIP_ASSERT_NXT(a_write_ack, clk_i, rst_ni,
    in_acc && (in_op == pip_pkg::OP_WRITE),
    (state_q == pip_pkg::ST_DONE) && !res_answer_q && !res_inside_q)

  // a finished item lands in the output register when it is free
  `PIP_ASSERT_NXT(a_out_load, clk_i, rst_ni,
    (state_q == pip_pkg::ST_DONE) && out_free,
    m_axis_tvalid && (state_q == pip_pkg::ST_IDLE))

endmodule

`default_nettype wire
